/* sv/sit_pkg.sv */
// Shared types and constants for the segment intersection test core.
package sit_pkg;

	localparam int COORD_W = 16;
	localparam int DW = COORD_W + 1;
	localparam int PW = 2 * COORD_W + 2;
	localparam int SW = 2 * COORD_W + 3;
	localparam int NW = 2 * COORD_W + 2;
	localparam int QW = COORD_W + 1;
	localparam int QUEUE_DEPTH = 8;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t seg_a_x0;
		coord_t seg_a_y0;
		coord_t seg_a_x1;
		coord_t seg_a_y1;
		coord_t seg_b_x0;
		coord_t seg_b_y0;
		coord_t seg_b_x1;
		coord_t seg_b_y1;
	} seg_t;

	typedef struct packed {
		logic   hit;
		coord_t cross_x;
		coord_t cross_y;
	} res_t;

	// Classified pair handed from the front end to the divider back end.
	typedef struct packed {
		logic               hit;
		logic               par;
		logic [NW-1:0]      na;
		logic [NW-1:0]      den;
		coord_t             ax0;
		coord_t             ay0;
		logic [COORD_W-1:0] mx;
		logic [COORD_W-1:0] my;
		logic               nx;
		logic               ny;
	} job_t;

	typedef struct packed {
		logic [NW-1:0] r;
		logic [QW-1:0] q;
	} div_t;

endpackage

/* sv/segment_intersection_test_core.sv */
// Pipeline: 3 front stages, one queue slot, COORD_W+1 divider stages and the output register.
// Throughput: one segment pair per cycle while seg_stall is low; the divider retires one quotient digit per stage.
// The front stalls only when the queue could not hold a new pair beside every pair already in flight.
// Reset clears all valid bits, queue pointers and the output valid; payload is not reset.
module segment_intersection_test_core import sit_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic seg_valid,
	output logic seg_stall,
	input  seg_t seg,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);
	logic push, pop;
	job_t wr_job, rd_job;
	logic [$clog2(DEPTH+1)-1:0] q_count;

	sit_front #(.DEPTH(DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.q_count   (q_count),
		.push      (push),
		.job       (wr_job)
	);

	sit_queue #(.DEPTH(DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.count  (q_count)
	);

	sit_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_count != '0),
		.job       (rd_job),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// A miss carries a zero point.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.cross_x == '0 && res.cross_y == '0)
		else $error("miss with nonzero point");

endmodule

/* sv/sit_front.sv */
// Front end: differences, cross products and hit classification.
module sit_front import sit_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         seg_valid,
	output logic                         seg_stall,
	input  seg_t                         seg,
	input  logic [$clog2(DEPTH+1)-1:0]   q_count,
	output logic                         push,
	output job_t                         job
);
	localparam int CW = $clog2(DEPTH + 1);

	logic en;
	logic v_s1, v_s2, v_s3;
	logic [CW:0] occ;

	logic signed [DW-1:0] ax_s1, ay_s1, bx_s1, by_s1, abx_s1, aby_s1;
	coord_t ax0_s1, ay0_s1;
	logic signed [PW-1:0] p_axby_s2, p_bxay_s2, p_bxaby_s2, p_byabx_s2, p_axaby_s2, p_ayabx_s2;
	logic signed [DW-1:0] ax_s2, ay_s2;
	coord_t ax0_s2, ay0_s2;
	logic signed [SW-1:0] den_s3, na_s3, nb_s3;
	logic signed [DW-1:0] ax_s3, ay_s3;
	coord_t ax0_s3, ay0_s3;

	logic signed [SW-1:0] dn, nan, nbn;
	logic neg, dz;
	logic signed [DW-1:0] amx, amy;

	// Everything in flight must fit in the queue, so the front freezes as a whole.
	assign occ = (CW+1)'(q_count) + (CW+1)'(v_s1) + (CW+1)'(v_s2) + (CW+1)'(v_s3);
	assign en = occ < (CW+1)'(DEPTH);
	assign seg_stall = !en;
	assign push = v_s3 && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= seg_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= {seg.seg_a_x1[COORD_W-1], seg.seg_a_x1} - {seg.seg_a_x0[COORD_W-1], seg.seg_a_x0};
			ay_s1  <= {seg.seg_a_y1[COORD_W-1], seg.seg_a_y1} - {seg.seg_a_y0[COORD_W-1], seg.seg_a_y0};
			bx_s1  <= {seg.seg_b_x1[COORD_W-1], seg.seg_b_x1} - {seg.seg_b_x0[COORD_W-1], seg.seg_b_x0};
			by_s1  <= {seg.seg_b_y1[COORD_W-1], seg.seg_b_y1} - {seg.seg_b_y0[COORD_W-1], seg.seg_b_y0};
			abx_s1 <= {seg.seg_a_x0[COORD_W-1], seg.seg_a_x0} - {seg.seg_b_x0[COORD_W-1], seg.seg_b_x0};
			aby_s1 <= {seg.seg_a_y0[COORD_W-1], seg.seg_a_y0} - {seg.seg_b_y0[COORD_W-1], seg.seg_b_y0};
			ax0_s1 <= seg.seg_a_x0;
			ay0_s1 <= seg.seg_a_y0;

			p_axby_s2  <= PW'(ax_s1) * PW'(by_s1);
			p_bxay_s2  <= PW'(bx_s1) * PW'(ay_s1);
			p_bxaby_s2 <= PW'(bx_s1) * PW'(aby_s1);
			p_byabx_s2 <= PW'(by_s1) * PW'(abx_s1);
			p_axaby_s2 <= PW'(ax_s1) * PW'(aby_s1);
			p_ayabx_s2 <= PW'(ay_s1) * PW'(abx_s1);
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			ax0_s2 <= ax0_s1;
			ay0_s2 <= ay0_s1;

			den_s3 <= SW'(p_axby_s2) - SW'(p_bxay_s2);
			na_s3  <= SW'(p_bxaby_s2) - SW'(p_byabx_s2);
			nb_s3  <= SW'(p_axaby_s2) - SW'(p_ayabx_s2);
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			ax0_s3 <= ax0_s2;
			ay0_s3 <= ay0_s2;
		end
	end

	always_comb begin
		neg = den_s3[SW-1];
		dz  = (den_s3 == '0);
		dn  = neg ? -den_s3 : den_s3;
		nan = neg ? -na_s3 : na_s3;
		nbn = neg ? -nb_s3 : nb_s3;
		amx = ax_s3[DW-1] ? -ax_s3 : ax_s3;
		amy = ay_s3[DW-1] ? -ay_s3 : ay_s3;

		job.par = dz;
		if (dz) begin
			job.hit = (na_s3 == '0) && (nb_s3 == '0);
		end else begin
			job.hit = !nan[SW-1] && !nbn[SW-1] && (nan <= dn) && (nbn <= dn);
		end
		job.na  = nan[NW-1:0];
		job.den = dn[NW-1:0];
		job.ax0 = ax0_s3;
		job.ay0 = ay0_s3;
		job.mx  = amx[COORD_W-1:0];
		job.my  = amy[COORD_W-1:0];
		job.nx  = ax_s3[DW-1];
		job.ny  = ay_s3[DW-1];
	end

endmodule

/* sv/sit_queue.sv */
// Short queue that decouples the classifier from the divider pipeline.
module sit_queue import sit_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  job_t                       wr_job,
	input  logic                       pop,
	output job_t                       rd_job,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign count  = count_q;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> count_q != CW'(DEPTH) || pop)
		else $error("queue push while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> count_q != '0)
		else $error("queue pop while empty");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

/* sv/sit_back.sv */
// Back end: radix-2 long division per coordinate and point assembly.
module sit_back import sit_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic pop,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);
	logic en;
	logic v_s  [COORD_W+1];
	job_t jb_s [COORD_W+1];
	div_t dx_s [COORD_W+1];
	div_t dy_s [COORD_W+1];
	logic res_valid_q;
	res_t res_q;
	job_t jl;
	logic [COORD_W-1:0] qx, qy;
	coord_t px, py;

	// Each step brings in one bit of |delta|, so the partial remainder stays below
	// 3*den and the quotient digit is 0, 1 or 2.
	function automatic div_t div_step(div_t cur, logic b, logic [NW-1:0] na,
			logic [NW-1:0] den);
		logic [NW:0] t, d1, d2;
		logic [1:0] dg;
		div_t o;
		t  = ({1'b0, cur.r} << 1) + (b ? {1'b0, na} : '0);
		d1 = {1'b0, den};
		d2 = {den, 1'b0};
		if (t >= d2) begin
			t  = t - d2;
			dg = 2'd2;
		end else if (t >= d1) begin
			t  = t - d1;
			dg = 2'd1;
		end else begin
			dg = 2'd0;
		end
		o.r = t[NW-1:0];
		o.q = (cur.q << 1) + QW'(dg);
		return o;
	endfunction

	assign en = !res_valid_q || !res_stall;
	assign pop = en && job_valid;
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			jb_s[0] <= job;
			dx_s[0] <= '0;
			dy_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < COORD_W; i++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				jb_s[i+1] <= jb_s[i];
				dx_s[i+1] <= div_step(dx_s[i], jb_s[i].mx[COORD_W-1-i], jb_s[i].na, jb_s[i].den);
				dy_s[i+1] <= div_step(dy_s[i], jb_s[i].my[COORD_W-1-i], jb_s[i].na, jb_s[i].den);
			end
		end
	end

	always_comb begin
		jl = jb_s[COORD_W];
		qx = dx_s[COORD_W].q[COORD_W-1:0];
		qy = dy_s[COORD_W].q[COORD_W-1:0];
		if (!jl.hit) begin
			px = '0;
			py = '0;
		end else if (jl.par) begin
			px = jl.ax0;
			py = jl.ay0;
		end else begin
			px = jl.nx ? jl.ax0 - qx : jl.ax0 + qx;
			py = jl.ny ? jl.ay0 - qy : jl.ay0 + qy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= v_s[COORD_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.hit     <= jl.hit;
			res_q.cross_x <= px;
			res_q.cross_y <= py;
		end
	end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the segment intersection test core.
module tb;
	import sit_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = COORD_W + 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1900;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_e;

	typedef struct {
		seg_t pair;
		logic typed;
		res_t outcome;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic seg_valid;
	logic seg_stall;
	seg_t seg;
	logic res_valid;
	logic res_stall;
	res_t res;

	res_t expected_q[$];
	idle_mode_e idle_mode;
	int cycle_count;
	int error_count;

	segment_intersection_test_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg(seg),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Exact crossing test, done on wide signed integers.
	function automatic res_t predict_crossing(seg_t p);
		longint ax, ay, bx, by, abx, aby, dlt;
		logic signed [127:0] den, na, nb, prod, quo;
		res_t r;
		ax = longint'(p.seg_a_x1) - longint'(p.seg_a_x0);
		ay = longint'(p.seg_a_y1) - longint'(p.seg_a_y0);
		bx = longint'(p.seg_b_x1) - longint'(p.seg_b_x0);
		by = longint'(p.seg_b_y1) - longint'(p.seg_b_y0);
		abx = longint'(p.seg_a_x0) - longint'(p.seg_b_x0);
		aby = longint'(p.seg_a_y0) - longint'(p.seg_b_y0);
		den = 128'(ax) * 128'(by) - 128'(bx) * 128'(ay);
		na = 128'(bx) * 128'(aby) - 128'(by) * 128'(abx);
		nb = 128'(ax) * 128'(aby) - 128'(ay) * 128'(abx);
		r = '0;
		if (den == 0) begin
			if (na == 0 && nb == 0) begin
				r.hit = 1'b1;
				r.cross_x = p.seg_a_x0;
				r.cross_y = p.seg_a_y0;
			end
		end else begin
			if (den < 0) begin
				den = -den;
				na = -na;
				nb = -nb;
			end
			if (na >= 0 && nb >= 0 && na <= den && nb <= den) begin
				r.hit = 1'b1;
				// Signed division truncates toward zero, as the point requires.
				prod = na * 128'(ax);
				quo = prod / den;
				dlt = longint'(quo);
				r.cross_x = coord_t'(longint'(p.seg_a_x0) + dlt);
				prod = na * 128'(ay);
				quo = prod / den;
				dlt = longint'(quo);
				r.cross_y = coord_t'(longint'(p.seg_a_y0) + dlt);
			end
		end
		return r;
	endfunction

	function automatic seg_t make_pair(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		seg_t p;
		p.seg_a_x0 = coord_t'(ax0);
		p.seg_a_y0 = coord_t'(ay0);
		p.seg_a_x1 = coord_t'(ax1);
		p.seg_a_y1 = coord_t'(ay1);
		p.seg_b_x0 = coord_t'(bx0);
		p.seg_b_y0 = coord_t'(by0);
		p.seg_b_x1 = coord_t'(bx1);
		p.seg_b_y1 = coord_t'(by1);
		return p;
	endfunction

	function automatic coord_t rand_coord(int span);
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return coord_t'(int'($urandom_range(0, 2 * span)) - span);
		endcase
	endfunction

	// Mostly crossing or touching pairs, built around a shared point; the rest are collinear or parallel pairs and noise.
	function automatic seg_t rand_pair();
		seg_t p;
		int span;
		coord_t cx, cy;
		span = $urandom_range(0, 3) == 0 ? 32767 : int'($urandom_range(2, 2000));
		p = seg_t'({$urandom, $urandom, $urandom, $urandom});
		case ($urandom_range(0, 9))
			0, 1: begin
			end
			2: begin
				// Collinear or parallel segments.
				p.seg_a_x0 = rand_coord(span);
				p.seg_a_y0 = rand_coord(span);
				p.seg_a_x1 = p.seg_a_x0 + coord_t'($urandom_range(0, 40));
				p.seg_a_y1 = p.seg_a_y0 + coord_t'($urandom_range(0, 40));
				p.seg_b_x0 = p.seg_a_x0 + (p.seg_a_x1 - p.seg_a_x0) * coord_t'($urandom_range(0, 3));
				p.seg_b_y0 = p.seg_a_y0 + (p.seg_a_y1 - p.seg_a_y0) * coord_t'($urandom_range(0, 3))
					+ coord_t'($urandom_range(0, 1));
				p.seg_b_x1 = p.seg_b_x0 - (p.seg_a_x1 - p.seg_a_x0);
				p.seg_b_y1 = p.seg_b_y0 - (p.seg_a_y1 - p.seg_a_y0);
			end
			default: begin
				cx = rand_coord(span / 2);
				cy = rand_coord(span / 2);
				p.seg_a_x0 = cx - coord_t'($urandom_range(0, span / 2));
				p.seg_a_y0 = cy - coord_t'($urandom_range(0, span / 2));
				p.seg_a_x1 = cx + coord_t'($urandom_range(0, span / 2));
				p.seg_a_y1 = cy + coord_t'($urandom_range(0, span / 2));
				p.seg_b_x0 = cx + coord_t'($urandom_range(0, span / 2));
				p.seg_b_y0 = cy - coord_t'($urandom_range(0, span / 2));
				p.seg_b_x1 = cx - coord_t'($urandom_range(0, span / 2));
				p.seg_b_y1 = cy + coord_t'($urandom_range(0, span / 2));
			end
		endcase
		return p;
	endfunction

	function automatic bit sender_idles();
		if (idle_mode == IDLE_SENDER) return $urandom_range(0, 99) < 76;
		if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 24;
		return 1'b0;
	endfunction

	// Drives one transaction and holds it until the core takes it.
	task automatic send_pair(seg_t p, logic typed, res_t outcome);
		while (sender_idles()) begin
			seg_valid <= 1'b0;
			@(posedge clk);
		end
		seg_valid <= 1'b1;
		seg <= p;
		@(posedge clk);
		while (seg_stall) @(posedge clk);
		expected_q.push_back(typed ? outcome : predict_crossing(p));
	endtask

	always @(posedge clk) begin
		if (idle_mode == IDLE_RECEIVER) res_stall <= $urandom_range(0, 99) < 76;
		else if (idle_mode == IDLE_BOTH) res_stall <= $urandom_range(0, 99) < 24;
		else res_stall <= 1'b0;
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_q.size() == 0) begin
				$display("%t: result with none expected: actual %h", $realtime, res);
				error_count++;
			end else begin
				want = expected_q.pop_front();
				if (res.hit !== want.hit) begin
					$display("%t: hit expected %b actual %b", $realtime, want.hit, res.hit);
					error_count++;
				end
				if (res.cross_x !== want.cross_x) begin
					$display("%t: cross_x expected %0d actual %0d", $realtime,
						want.cross_x, res.cross_x);
					error_count++;
				end
				if (res.cross_y !== want.cross_y) begin
					$display("%t: cross_y expected %0d actual %0d", $realtime,
						want.cross_y, res.cross_y);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		res_t miss;
		res_t r;
		miss = '0;
		error_count = 0;
		cycle_count = 0;
		idle_mode = IDLE_NONE;
		arst_n = 1'b0;
		seg_valid = 1'b0;
		seg = '0;
		res_stall = 1'b0;

		// Directed rows: a typed result where it is plain, otherwise the predictor decides.
		r = '{1'b1, 16'sd0, 16'sd0};
		rows.push_back('{make_pair(-10, -10, 10, 10, -10, 10, 10, -10), 1'b1, r});
		rows.push_back('{make_pair(0, 0, 10, 0, 0, 5, 10, 5), 1'b1, miss});
		r = '{1'b1, 16'sd3, 16'sd3};
		rows.push_back('{make_pair(3, 3, 20, 20, 1, 1, 50, 50), 1'b1, r});
		rows.push_back('{make_pair(0, 0, 1, 1, 5, 5, 9, 9), 1'b0, miss});
		r = '{1'b1, 16'sd7, -16'sd4};
		rows.push_back('{make_pair(7, -4, 7, -4, 7, -4, 7, -4), 1'b1, r});
		rows.push_back('{make_pair(7, -4, 7, -4, 0, 0, 1, 1), 1'b1, miss});
		r = '{1'b1, 16'sd10, 16'sd0};
		rows.push_back('{make_pair(0, 0, 10, 0, 10, -5, 10, 5), 1'b1, r});
		rows.push_back('{make_pair(0, 0, 10, 0, 11, -5, 11, 5), 1'b1, miss});
		rows.push_back('{make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
			1'b0, miss});
		rows.push_back('{make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767),
			1'b0, miss});
		rows.push_back('{make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 1'b0, miss});
		rows.push_back('{make_pair(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767),
			1'b0, miss});
		rows.push_back('{make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
			1'b0, miss});
		rows.push_back('{make_pair(0, 0, 3, 7, 3, 0, 0, 7), 1'b0, miss});
		rows.push_back('{make_pair(0, 0, -3, -7, -3, 0, 0, -7), 1'b0, miss});
		rows.push_back('{make_pair(1, 2, 4, 8, 1, 2, -5, 9), 1'b0, miss});
		rows.push_back('{make_pair(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0, miss});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			row = rows[i];
			send_pair(row.pair, row.typed, row.outcome);
		end
		seg_valid <= 1'b0;

		// Let every result drain before the random part.
		while (expected_q.size() != 0) @(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Step through every idling phase in turn.
			if (n % 200 == 0) idle_mode = idle_mode_e'((n / 200) % 4);
			if (n == RANDOM_ITEMS / 2) begin
				seg_valid <= 1'b0;
				@(posedge clk);
				while (expected_q.size() != 0) @(posedge clk);
			end
			send_pair(rand_pair(), 1'b0, miss);
		end
		seg_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		idle_mode = IDLE_NONE;
		repeat (LATENCY * 2) @(posedge clk);

		if (error_count == 0 && expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
